### sv/rreq_pkg.sv
// Shared types, constants and helpers of the escalating-quantum round-robin scheduler.
package rreq_pkg;

	localparam int SLOTS_DEF  = 8;
	localparam int BURST_W    = 16;
	localparam int OWNER_W    = 16;
	localparam int ROUNDS_W   = 8;
	localparam int QUANT_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_SLOT_W = 3;
	localparam int OUT_CNT_W  = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_EARLY      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_MIDDLE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_LATE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EARLY_ROUND_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_ROUND_LIMIT = 3'd4;

	localparam logic [QUANT_W-1:0]  RST_QUANTUM_EARLY      = 8'd4;
	localparam logic [QUANT_W-1:0]  RST_QUANTUM_MIDDLE     = 8'd6;
	localparam logic [QUANT_W-1:0]  RST_QUANTUM_LATE       = 8'd10;
	localparam logic [ROUNDS_W-1:0] RST_EARLY_ROUND_LIMIT  = 8'd2;
	localparam logic [ROUNDS_W-1:0] RST_MIDDLE_ROUND_LIMIT = 8'd5;

	localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = 8'hFF;

	typedef struct packed {
		logic [QUANT_W-1:0]  quantum_early;
		logic [QUANT_W-1:0]  quantum_middle;
		logic [QUANT_W-1:0]  quantum_late;
		logic [ROUNDS_W-1:0] early_round_limit;
		logic [ROUNDS_W-1:0] middle_round_limit;
	} cfg_t;

	// Write enables of the three slot arrays.
	typedef struct packed {
		logic rem;
		logic rounds;
		logic owner;
	} mem_we_t;

	typedef struct packed {
		logic                  ran;
		logic [OUT_SLOT_W-1:0] run_slot;
		logic                  finished;
		logic [OWNER_W-1:0]    finished_owner;
		logic                  admit_ok;
		logic [OUT_SLOT_W-1:0] admit_slot;
		logic [OUT_CNT_W-1:0]  active_count;
	} res_t;

	// Slice length for a job with the given round count; zero acts as one.
	function automatic logic [QUANT_W-1:0] pick_quantum(cfg_t cfg, logic [ROUNDS_W-1:0] rounds);
		logic [QUANT_W-1:0] q;
		if (rounds < cfg.early_round_limit) begin
			q = cfg.quantum_early;
		end else if (rounds < cfg.middle_round_limit) begin
			q = cfg.quantum_middle;
		end else begin
			q = cfg.quantum_late;
		end
		return (q == '0) ? QUANT_W'(1) : q;
	endfunction

endpackage

### sv/rreq_slot_mem.sv
// Slot table storage: remaining work, round count and owner tag per slot.
module rreq_slot_mem #(
	parameter int SLOTS = rreq_pkg::SLOTS_DEF,
	localparam int SLOT_W = $clog2(SLOTS)
) (
	input  logic                         clk,
	input  rreq_pkg::mem_we_t            we,
	input  logic [SLOT_W-1:0]            wr_addr,
	input  logic [rreq_pkg::BURST_W-1:0]  wr_rem,
	input  logic [rreq_pkg::ROUNDS_W-1:0] wr_rounds,
	input  logic [rreq_pkg::OWNER_W-1:0]  wr_owner,
	input  logic [SLOT_W-1:0]            rd_addr,
	output logic [rreq_pkg::BURST_W-1:0]  rd_rem,
	output logic [rreq_pkg::ROUNDS_W-1:0] rd_rounds,
	output logic [rreq_pkg::OWNER_W-1:0]  rd_owner
);
	import rreq_pkg::*;

	logic [BURST_W-1:0]  rem_mem    [SLOTS];
	logic [ROUNDS_W-1:0] rounds_mem [SLOTS];
	logic [OWNER_W-1:0]  owner_mem  [SLOTS];

	always_ff @(posedge clk) begin
		if (we.rem) begin
			rem_mem[wr_addr] <= wr_rem;
		end
		if (we.rounds) begin
			rounds_mem[wr_addr] <= wr_rounds;
		end
		if (we.owner) begin
			owner_mem[wr_addr] <= wr_owner;
		end
		rd_rem    <= rem_mem[rd_addr];
		rd_rounds <= rounds_mem[rd_addr];
		rd_owner  <= owner_mem[rd_addr];
	end

endmodule

### sv/rreq_ctrl.sv
// Scheduler sequencer: occupancy scan, slice bookkeeping and result build.
module rreq_ctrl #(
	parameter int SLOTS = rreq_pkg::SLOTS_DEF,
	localparam int SLOT_W = $clog2(SLOTS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rreq_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_kind,
	input  logic [rreq_pkg::BURST_W-1:0]  in_burst,
	input  logic [rreq_pkg::OWNER_W-1:0]  in_owner,
	output logic                         res_valid,
	input  logic                         res_ready,
	output rreq_pkg::res_t               res,
	output rreq_pkg::mem_we_t            mem_we,
	output logic [SLOT_W-1:0]            wr_addr,
	output logic [rreq_pkg::BURST_W-1:0]  wr_rem,
	output logic [rreq_pkg::ROUNDS_W-1:0] wr_rounds,
	output logic [rreq_pkg::OWNER_W-1:0]  wr_owner,
	output logic [SLOT_W-1:0]            rd_addr,
	input  logic [rreq_pkg::BURST_W-1:0]  rd_rem,
	input  logic [rreq_pkg::ROUNDS_W-1:0] rd_rounds,
	input  logic [rreq_pkg::OWNER_W-1:0]  rd_owner
);
	import rreq_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADMIT_SCAN,
		ST_TICK_SCAN,
		ST_READ,
		ST_EXEC,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [BURST_W-1:0]  burst_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SLOT_W-1:0]   scan_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [QUANT_W-1:0]  slice_q;
	logic                new_slice_q;
	logic [SLOTS-1:0]    occ_q;
	logic [CNT_W-1:0]    count_q;
	res_t                res_q;

	logic [SLOT_W-1:0]   scan_next;
	logic [SLOT_W-1:0]   cur_next;
	logic [QUANT_W-1:0]  slice_cur;
	logic [QUANT_W-1:0]  slice_next;
	logic [BURST_W-1:0]  rem_new;
	logic                fin;
	logic                slice_end;

	assign scan_next = (scan_q == LAST_SLOT) ? '0 : scan_q + SLOT_W'(1);
	assign cur_next  = (cur_q == LAST_SLOT) ? '0 : cur_q + SLOT_W'(1);

	// One served tick: the slice length comes from the round count on a fresh slice.
	assign slice_cur  = new_slice_q ? pick_quantum(cfg, rd_rounds) : slice_q;
	assign rem_new    = rd_rem - BURST_W'(1);
	assign fin        = (rem_new == '0);
	assign slice_next = fin ? '0 : slice_cur - QUANT_W'(1);
	assign slice_end  = (slice_next == '0);

	always_comb begin
		mem_we    = '0;
		wr_addr   = cur_q;
		wr_rem    = rem_new;
		wr_rounds = rd_rounds + ROUNDS_W'(1);
		wr_owner  = owner_q;
		if (state_q == ST_ADMIT_SCAN && !occ_q[scan_q]) begin
			mem_we    = '{rem: 1'b1, rounds: 1'b1, owner: 1'b1};
			wr_addr   = scan_q;
			wr_rem    = burst_q;
			wr_rounds = '0;
		end else if (state_q == ST_EXEC) begin
			mem_we.rem    = 1'b1;
			mem_we.rounds = slice_end && (rd_rounds != ROUNDS_MAX);
		end
	end

	assign rd_addr   = cur_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			burst_q     <= '0;
			owner_q     <= '0;
			scan_q      <= '0;
			cur_q       <= '0;
			slice_q     <= '0;
			new_slice_q <= 1'b0;
			occ_q       <= '0;
			count_q     <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_q <= res_t'{active_count: OUT_CNT_W'(count_q), default: '0};
						if (in_kind) begin
							if (in_burst == '0 || count_q == FULL_CNT) begin
								state_q <= ST_DONE;
							end else begin
								burst_q <= in_burst;
								owner_q <= in_owner;
								scan_q  <= '0;
								state_q <= ST_ADMIT_SCAN;
							end
						end else if (slice_q != '0 && occ_q[cur_q]) begin
							new_slice_q <= 1'b0;
							state_q     <= ST_READ;
						end else begin
							slice_q <= '0;
							if (count_q == '0) begin
								state_q <= ST_DONE;
							end else begin
								scan_q  <= cur_q;
								state_q <= ST_TICK_SCAN;
							end
						end
					end
				end
				ST_ADMIT_SCAN: begin
					if (!occ_q[scan_q]) begin
						occ_q[scan_q]      <= 1'b1;
						count_q            <= count_q + CNT_W'(1);
						res_q.admit_ok     <= 1'b1;
						res_q.admit_slot   <= OUT_SLOT_W'(scan_q);
						res_q.active_count <= OUT_CNT_W'(count_q + CNT_W'(1));
						state_q            <= ST_DONE;
					end else begin
						scan_q <= scan_next;
					end
				end
				ST_TICK_SCAN: begin
					if (occ_q[scan_q]) begin
						cur_q       <= scan_q;
						new_slice_q <= 1'b1;
						state_q     <= ST_READ;
					end else begin
						scan_q <= scan_next;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					slice_q        <= slice_next;
					res_q.ran      <= 1'b1;
					res_q.run_slot <= OUT_SLOT_W'(cur_q);
					if (fin) begin
						occ_q[cur_q]         <= 1'b0;
						count_q              <= count_q - CNT_W'(1);
						res_q.finished       <= 1'b1;
						res_q.finished_owner <= rd_owner;
						res_q.active_count   <= OUT_CNT_W'(count_q - CNT_W'(1));
					end
					if (slice_end) begin
						cur_q <= cur_next;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/round_robin_escalating_quantum.sv
// Top level of the escalating-quantum round-robin scheduler.
//
// Input stream (s_axis_*): one transfer per item. s_axis_tuser is the kind
// (0 = time tick, 1 = admit a job); s_axis_tdata carries burst_length in
// bits 15:0 and owner_id in bits 31:16. Output stream (m_axis_*): one result
// transfer per input item, in order.
// Configuration: cfg_we / cfg_index / cfg_wdata write the five 8-bit
// registers (quanta and round limits); write only while the block is idle.
// Sequence from the input transfer to m_axis_tvalid: an admit scans the
// slots from 0 up to the lowest free one and writes it; a refused admit or
// a tick on an empty table goes straight to the result. A tick that continues
// a slice reads the current slot and then executes; a tick that starts a new
// slice first runs the occupancy scan from the current slot to the next
// occupied one. The single scan counter and the registered read port of the
// slot table set this sequence; one item is in work at a time and the
// sequencer returns to idle after handing off each result.
// Reset: all slots free, quanta 4/6/10, round limits 2/5, no slice active.
// Stall: a finished result waits in the output register; the next item is
// still taken and worked on, and its result holds until the register frees.
module round_robin_escalating_quantum #(
	parameter int SLOTS = rreq_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// burst_length [15:0], owner_id [31:16]
	input  logic [rreq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// kind [0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// ran [0], run_slot [3:1], finished [4], finished_owner [20:5],
	// admit_ok [21], admit_slot [24:22], active_count [28:25], zero [31:29]
	output logic [rreq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [rreq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rreq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import rreq_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);

	cfg_t                cfg_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                res_valid;
	logic                res_ready;
	res_t                res;
	mem_we_t             mem_we;
	logic [SLOT_W-1:0]   wr_addr;
	logic [BURST_W-1:0]  wr_rem;
	logic [ROUNDS_W-1:0] wr_rounds;
	logic [OWNER_W-1:0]  wr_owner;
	logic [SLOT_W-1:0]   rd_addr;
	logic [BURST_W-1:0]  rd_rem;
	logic [ROUNDS_W-1:0] rd_rounds;
	logic [OWNER_W-1:0]  rd_owner;

	// Configuration registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quantum_early      <= RST_QUANTUM_EARLY;
			cfg_q.quantum_middle     <= RST_QUANTUM_MIDDLE;
			cfg_q.quantum_late       <= RST_QUANTUM_LATE;
			cfg_q.early_round_limit  <= RST_EARLY_ROUND_LIMIT;
			cfg_q.middle_round_limit <= RST_MIDDLE_ROUND_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUANTUM_EARLY:      cfg_q.quantum_early      <= cfg_wdata;
				REG_QUANTUM_MIDDLE:     cfg_q.quantum_middle     <= cfg_wdata;
				REG_QUANTUM_LATE:       cfg_q.quantum_late       <= cfg_wdata;
				REG_EARLY_ROUND_LIMIT:  cfg_q.early_round_limit  <= cfg_wdata;
				REG_MIDDLE_ROUND_LIMIT: cfg_q.middle_round_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	rreq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_burst  (s_axis_tdata[BURST_W-1:0]),
		.in_owner  (s_axis_tdata[BURST_W+OWNER_W-1:BURST_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.wr_addr   (wr_addr),
		.wr_rem    (wr_rem),
		.wr_rounds (wr_rounds),
		.wr_owner  (wr_owner),
		.rd_addr   (rd_addr),
		.rd_rem    (rd_rem),
		.rd_rounds (rd_rounds),
		.rd_owner  (rd_owner)
	);

	rreq_slot_mem #(.SLOTS(SLOTS)) u_slot_mem (
		.clk       (clk),
		.we        (mem_we),
		.wr_addr   (wr_addr),
		.wr_rem    (wr_rem),
		.wr_rounds (wr_rounds),
		.wr_owner  (wr_owner),
		.rd_addr   (rd_addr),
		.rd_rem    (rd_rem),
		.rd_rounds (rd_rounds),
		.rd_owner  (rd_owner)
	);

	// Output register: load when empty or being drained this cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {3'b000, res.active_count, res.admit_slot, res.admit_ok,
				res.finished_owner, res.finished, res.run_slot, res.ran};
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
